// ===== rtl/pulse_generator_assert.svh =====
// Assertion macros for the pulse generator.
// Each macro takes a label, a clock, an active-low reset, an antecedent and a consequent.
`ifndef PULSE_GENERATOR_ASSERT_SVH
`define PULSE_GENERATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define PG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pulse generator check failed");
`define PG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pulse generator check failed");
`else
`define PG_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/pg_pkg.sv =====
package pg_pkg;

    // Field widths.
    localparam int TIME_W   = 32;
    localparam int PERIOD_W = 31;
    localparam int DUTY_W   = 17;
    localparam int DIFF_W   = TIME_W + 1;
    localparam int THR_W    = PERIOD_W + DUTY_W;
    localparam int FRAC_W   = 16;
    localparam int CFG_IDX_W = 3;

    // The remainder unit retires one dividend bit per cycle.
    localparam int REM_STEPS = DIFF_W;
    localparam int REM_CNT_W = $clog2(REM_STEPS + 1);

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LEVEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_START_TIME = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP  = 3'd7;

    // Reset values of the registers.
    localparam logic [TIME_W-1:0]   RST_HIGH_LEVEL = 32'd196608;
    localparam logic [TIME_W-1:0]   RST_LOW_LEVEL  = 32'd0;
    localparam logic [PERIOD_W-1:0] RST_PERIOD     = 31'd131072;
    localparam logic [TIME_W-1:0]   RST_DELAY      = 32'd0;
    localparam logic [DUTY_W-1:0]   RST_DUTY       = 17'd32768;
    localparam logic                RST_MODE       = 1'b1;
    localparam logic [TIME_W-1:0]   RST_START_TIME = 32'd0;
    localparam logic [TIME_W-1:0]   RST_TIME_STEP  = 32'd196608;

    // Status of the remainder unit as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_rem_stat;

endpackage

// ===== rtl/pg_rem.sv =====
// Restoring remainder unit: one dividend bit per cycle.
module pg_rem (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [pg_pkg::DIFF_W-1:0]    i_dividend,
    input  logic [pg_pkg::PERIOD_W-1:0]  i_divisor,
    output logic [pg_pkg::DIFF_W-1:0]    o_rem,
    output pg_pkg::t_rem_stat            o_stat
);
    import pg_pkg::*;

    logic [DIFF_W-1:0]    r_rem, n_rem;
    logic [DIFF_W-1:0]    r_dvd, n_dvd;
    logic [REM_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_done, n_done;
    logic [DIFF_W-1:0]    shifted;
    logic [DIFF_W-1:0]    div_ext;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        div_ext = {{(DIFF_W - PERIOD_W){1'b0}}, i_divisor};
        shifted = {r_rem[DIFF_W-2:0], r_dvd[DIFF_W-1]};
        n_rem   = r_rem;
        n_dvd   = r_dvd;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        if (i_start) begin
            n_rem = '0;
            n_dvd = i_dividend;
            n_cnt = REM_CNT_W'(REM_STEPS);
        end else if (r_cnt != '0) begin
            n_rem  = (shifted >= div_ext) ? (shifted - div_ext) : shifted;
            n_dvd  = {r_dvd[DIFF_W-2:0], 1'b0};
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == REM_CNT_W'(1));
        end
    end

    // Control state is reset; the datapath is not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvd <= n_dvd;
    end

    assign o_rem       = r_rem;
    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;

endmodule

// ===== rtl/pulse_generator.sv =====
// Rectangular pulse generator with delay and duty cycle.
// Input channel: i_valid, i_time_in, o_stall. A word is taken when i_valid is high
// and o_stall is low. Output channel: o_valid, o_level, o_is_high, i_stall. A word
// leaves when o_valid is high and i_stall is low.
// Configuration: i_cfg_valid, i_cfg_index, i_cfg_data, o_cfg_ready (always ready).
// Write registers only while no word is in flight. Writing start_time also loads
// the internal time accumulator.
// For each word the time difference and the duty threshold are captured at the
// accepting edge; the bit-serial remainder unit then works through the 33-bit
// difference one bit per cycle, the phase compare is registered in the sequencer,
// and the result is loaded into the output register. o_stall stays high until the
// result is in the output register, so a new word can be taken while the previous
// result waits. When i_stall holds the output, a finished result waits in the
// sequencer and o_stall stays high until the output register frees up.
// Synchronous active-low reset sets the configuration registers to their documented
// values, loads the accumulator with the reset start_time, idles the sequencer and empties the output.
module pulse_generator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [31:0]            i_time_in,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [31:0]            o_level,
    output logic                          o_is_high,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);
    import pg_pkg::*;
    `include "pulse_generator_assert.svh"

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    // Configuration registers.
    logic [TIME_W-1:0]   r_high_level;
    logic [TIME_W-1:0]   r_low_level;
    logic [PERIOD_W-1:0] r_period;
    logic [TIME_W-1:0]   r_delay;
    logic [DUTY_W-1:0]   r_duty;
    logic                r_mode;
    logic [TIME_W-1:0]   r_time_step;
    logic [TIME_W-1:0]   r_acc, n_acc;

    logic [1:0]          r_state, n_state;
    logic                r_neg;
    logic [THR_W-1:0]    r_thr;
    logic                r_high;
    logic                r_out_valid;
    logic [TIME_W-1:0]   r_level;
    logic                r_is_high;

    logic                in_acc;
    logic                cfg_wr;
    logic                out_free;
    logic [TIME_W-1:0]   t_sel;
    logic [DIFF_W:0]     diff_full;
    logic [TIME_W:0]     acc_sum;
    logic [DIFF_W-1:0]   rem;
    t_rem_stat           rem_stat;
    logic                high_now;

    assign in_acc      = i_valid && !o_stall;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign out_free    = !r_out_valid || !i_stall;
    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != S_IDLE);

    // Time difference against the delay, one bit wider so the sign survives.
    always_comb begin
        t_sel     = r_mode ? r_acc : i_time_in;
        diff_full = {{2{t_sel[TIME_W-1]}}, t_sel} - {{2{r_delay[TIME_W-1]}}, r_delay};
    end

    // Saturating accumulator step.
    always_comb begin
        acc_sum = {r_acc[TIME_W-1], r_acc} + {r_time_step[TIME_W-1], r_time_step};
        if (acc_sum[TIME_W] != acc_sum[TIME_W-1]) begin
            n_acc = acc_sum[TIME_W] ? {1'b1, {(TIME_W-1){1'b0}}}
                                    : {1'b0, {(TIME_W-1){1'b1}}};
        end else begin
            n_acc = acc_sum[TIME_W-1:0];
        end
    end

    // Configuration writes; an item advances the accumulator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_level <= RST_HIGH_LEVEL;
            r_low_level  <= RST_LOW_LEVEL;
            r_period     <= RST_PERIOD;
            r_delay      <= RST_DELAY;
            r_duty       <= RST_DUTY;
            r_mode       <= RST_MODE;
            r_time_step  <= RST_TIME_STEP;
            r_acc        <= RST_START_TIME;
        end else begin
            if (in_acc) begin
                r_acc <= n_acc;
            end
            if (cfg_wr) begin
                unique case (i_cfg_index)
                    REG_HIGH_LEVEL: r_high_level <= i_cfg_data;
                    REG_LOW_LEVEL:  r_low_level  <= i_cfg_data;
                    REG_PERIOD:     r_period     <= i_cfg_data[PERIOD_W-1:0];
                    REG_DELAY:      r_delay      <= i_cfg_data;
                    REG_DUTY:       r_duty       <= i_cfg_data[DUTY_W-1:0];
                    REG_MODE:       r_mode       <= i_cfg_data[0];
                    REG_START_TIME: r_acc        <= i_cfg_data;
                    REG_TIME_STEP:  r_time_step  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Operands captured at acceptance: sign of the difference and duty threshold.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_neg  <= diff_full[DIFF_W];
            r_thr  <= r_period * r_duty;
        end
    end

    pg_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_acc),
        .i_dividend (diff_full[DIFF_W-1:0]),
        .i_divisor  (r_period),
        .o_rem      (rem),
        .o_stat     (rem_stat)
    );

    // Exact Q33.16 compare of the phase against period times duty.
    assign high_now = !r_neg && ({rem, {FRAC_W{1'b0}}} <= {1'b0, r_thr});

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc) n_state = S_DIV;
            S_DIV:  if (rem_stat.done) n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result word and output register.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV && rem_stat.done) begin
            r_high <= high_now;
        end
        if (r_state == S_OUT && out_free) begin
            r_level   <= r_high ? r_high_level : r_low_level;
            r_is_high <= r_high;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_level   = r_level;
    assign o_is_high = r_is_high;

    `PG_ASSERT_NEXT(a_accept_starts_rem, i_clk, i_rst_n, in_acc, r_state == S_DIV && rem_stat.busy)
    `PG_ASSERT_SAME(a_done_in_div, i_clk, i_rst_n, rem_stat.done, r_state == S_DIV)
    `PG_ASSERT_SAME(a_idle_rem_quiet, i_clk, i_rst_n, r_state == S_IDLE, !rem_stat.busy)

endmodule

// ===== tb/pulse_generator_checker.sv =====
module pulse_generator_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic signed [pg_pkg::TIME_W-1:0]    i_time_in,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic signed [pg_pkg::TIME_W-1:0]    i_level,
    input  logic                                i_is_high,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [pg_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [31:0]                         i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import pg_pkg::*;

    typedef struct packed {
        logic signed [TIME_W-1:0] level;
        logic                     is_high;
    } t_pulse_word;

    // Shadow copy of the register file and the internal time accumulator.
    logic signed [TIME_W-1:0] high_q;
    logic signed [TIME_W-1:0] low_q;
    logic [PERIOD_W-1:0]      period_q;
    logic signed [TIME_W-1:0] delay_q;
    logic [DUTY_W-1:0]        duty_q;
    logic                     mode_q;
    logic signed [TIME_W-1:0] step_q;
    logic signed [TIME_W-1:0] acc_q;

    // Levels still owed by the block, oldest first.
    t_pulse_word level_q[$];

    // Works out the output word for one time word under the current settings.
    // The remainder is taken on the exact nonnegative 33-bit difference, and a
    // zero period leaves the whole difference as the phase.
    function automatic t_pulse_word pulse_predict(input logic signed [TIME_W-1:0] time_in);
        logic signed [TIME_W-1:0] t_now;
        longint unsigned          offset;
        longint unsigned          phase;
        longint unsigned          thresh;
        t_pulse_word              word;
        t_now        = mode_q ? acc_q : time_in;
        word.is_high = 1'b0;
        if (t_now >= delay_q) begin
            offset = longint'(t_now) - longint'(delay_q);
            phase  = (period_q != '0) ? offset % longint'(period_q) : offset;
            thresh = longint'(period_q) * longint'(duty_q);
            word.is_high = ((phase << FRAC_W) <= thresh);
        end
        word.level = word.is_high ? high_q : low_q;
        return word;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_pulse_word want;
        longint      acc_sum;
        if (!i_rst_n) begin
            high_q   = RST_HIGH_LEVEL;
            low_q    = RST_LOW_LEVEL;
            period_q = RST_PERIOD;
            delay_q  = RST_DELAY;
            duty_q   = RST_DUTY;
            mode_q   = RST_MODE;
            step_q   = RST_TIME_STEP;
            acc_q    = RST_START_TIME;
            level_q.delete();
        end else begin
            // Results leaving the block are matched against the oldest prediction.
            if (i_out_valid && !i_out_stall) begin
                if (level_q.size() == 0) begin
                    $error("level: no result expected, got %0d (is_high %0b)",
                           i_level, i_is_high);
                    o_fail_count++;
                end else begin
                    want = level_q.pop_front();
                    o_checked++;
                    if (i_level !== want.level) begin
                        $error("level: expected %0d, got %0d", want.level, i_level);
                        o_fail_count++;
                    end
                    if (i_is_high !== want.is_high) begin
                        $error("is_high: expected %0b, got %0b", want.is_high, i_is_high);
                        o_fail_count++;
                    end
                end
            end

            // Register writes; a start time write also reloads the accumulator.
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_HIGH_LEVEL: high_q   = i_cfg_data;
                    REG_LOW_LEVEL:  low_q    = i_cfg_data;
                    REG_PERIOD:     period_q = i_cfg_data[PERIOD_W-1:0];
                    REG_DELAY:      delay_q  = i_cfg_data;
                    REG_DUTY:       duty_q   = i_cfg_data[DUTY_W-1:0];
                    REG_MODE:       mode_q   = i_cfg_data[0];
                    REG_START_TIME: acc_q    = i_cfg_data;
                    REG_TIME_STEP:  step_q   = i_cfg_data;
                    default: ;
                endcase
            end

            // Each accepted time word yields one level, then the accumulator
            // advances by the step with saturation at the signed limits.
            if (i_in_valid && !i_in_stall) begin
                level_q.push_back(pulse_predict(i_time_in));
                acc_sum = longint'(acc_q) + longint'(step_q);
                if (acc_sum > 64'sd2147483647) begin
                    acc_q = 32'sh7FFF_FFFF;
                end else if (acc_sum < -64'sd2147483648) begin
                    acc_q = 32'sh8000_0000;
                end else begin
                    acc_q = acc_sum[31:0];
                end
            end
        end
        o_pending = level_q.size();
    end

endmodule

// ===== tb/pulse_generator_tb.sv =====
module pulse_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pg_pkg::*;

    localparam int WORD_TARGET = 1700;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 48;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic signed [TIME_W-1:0] time_in = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [TIME_W-1:0] level;
    logic                     is_high;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [31:0]              cfg_data = '0;

    int fail_count;
    int pending;
    int checked;
    int words_sent;
    int settings_run;
    int cycle_count;
    bit idle_on = 1'b1;

    pulse_generator u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_stall     (in_stall),
        .i_time_in   (time_in),
        .o_valid     (out_valid),
        .i_stall     (out_stall),
        .o_level     (level),
        .o_is_high   (is_high),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    pulse_generator_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_time_in    (time_in),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_level      (level),
        .i_is_high    (is_high),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // 4 ns clock.
    always begin
        #2 clk = 1'b1;
        #2 clk = 0;
    end

    // Watchdog on the total run length.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped at cycle %0d with %0d results still due.",
                     cycle_count, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Random words half of the time, otherwise one of the sign and range extremes.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Offers one time word after a random gap (none while idle_on is clear) and returns at the edge that takes it.
    task automatic send_word(input logic [TIME_W-1:0] value);
        int gap;
        gap = idle_on ? $urandom_range(0, 16) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        time_in  <= value;
        @(negedge clk);
        while (in_stall) @(negedge clk);
        @(posedge clk);
        words_sent++;
    endtask

    // Holds one register write until the port takes it; the caller drops valid.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] index, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        while (!cfg_ready) @(negedge clk);
        @(posedge clk);
    endtask

    // Stops sending and waits for every outstanding level to come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
    endtask

    // Output side: for each word, optionally hold stall for a random number
    // of cycles after the result shows up, then take it.
    initial begin : result_stall
        int hold;
        forever begin
            hold = idle_on ? $urandom_range(0, 16) : 0;
            if (hold != 0) begin
                out_stall <= 1'b1;
                @(negedge clk);
                while (!out_valid) @(negedge clk);
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(negedge clk);
            while (!out_valid) @(negedge clk);
            @(posedge clk);
        end
    end

    initial begin : stimulus
        logic [PERIOD_W-1:0] per_w;
        logic [DUTY_W-1:0]   duty_w;
        logic [31:0]         delay_w;
        logic [31:0]         span;
        logic [31:0]         knee;
        logic [31:0]         step_w;
        logic [31:0]         tin;
        int                  count;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: internal time from zero, period 2.0, half duty.
        settings_run = 1;
        repeat (3) send_word($urandom);

        // External time with extreme levels, on both sides of the delay edge.
        drain();
        cfg_write(REG_MODE, 32'h0000_0000);
        cfg_write(REG_HIGH_LEVEL, 32'h7FFF_FFFF);
        cfg_write(REG_LOW_LEVEL, 32'h8000_0000);
        cfg_write(REG_DELAY, 32'h0001_0000);
        cfg_write(REG_PERIOD, 32'h0004_0000);
        cfg_write(REG_DUTY, 32'h0000_4000);
        cfg_valid <= 1'b0;
        settings_run++;
        send_word(32'h8000_0000);
        send_word(32'h7FFF_FFFF);
        send_word(32'h0000_FFFF);
        send_word(32'h0001_0000);
        send_word(32'h0002_0000);
        send_word(32'h0002_0001);
        send_word(32'h0005_0000);

        // Zero period (the top data bit is dropped): high only at the delay itself.
        drain();
        cfg_write(REG_PERIOD, 32'h8000_0000);
        cfg_write(REG_DELAY, 32'h0000_0000);
        cfg_write(REG_DUTY, 32'h0001_0000);
        cfg_valid <= 1'b0;
        settings_run++;
        send_word(32'h0000_0000);
        send_word(32'h0000_0001);
        send_word(32'hFFFF_FFFF);

        // Duty above one with the largest period and the most negative delay.
        drain();
        cfg_write(REG_PERIOD, 32'h7FFF_FFFF);
        cfg_write(REG_DELAY, 32'h8000_0000);
        cfg_write(REG_DUTY, 32'hFFFF_FFFF);
        cfg_valid <= 1'b0;
        settings_run++;
        send_word(32'h7FFF_FFFF);
        send_word(32'h8000_0000);

        // Zero duty: only a zero phase is high.
        drain();
        cfg_write(REG_DUTY, 32'hFFFE_0000);
        cfg_valid <= 1'b0;
        settings_run++;
        send_word(32'h8000_0000);
        send_word(32'h8000_0001);

        // Internal time driven into both saturation limits.
        drain();
        cfg_write(REG_MODE, 32'hFFFF_FFFF);
        cfg_write(REG_START_TIME, 32'h7FFF_0000);
        cfg_write(REG_TIME_STEP, 32'h7FFF_FFFF);
        cfg_valid <= 1'b0;
        settings_run++;
        repeat (3) send_word($urandom);
        drain();
        cfg_write(REG_START_TIME, 32'h8001_0000);
        cfg_write(REG_TIME_STEP, 32'h8000_0000);
        cfg_valid <= 1'b0;
        settings_run++;
        repeat (3) send_word($urandom);

        // Random settings; time words cluster around the delay and the duty
        // threshold so that both levels and the boundary come up often.
        while (words_sent < WORD_TARGET) begin
            drain();
            idle_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0: per_w = '0;
                1: per_w = 31'h7FFF_FFFF;
                2: per_w = 31'd1;
                3: per_w = 31'($urandom);
                default: per_w = 31'($urandom_range(1, 32'h0010_0000));
            endcase
            case ($urandom_range(0, 7))
                0: duty_w = '0;
                1: duty_w = 17'h1_0000;
                2: duty_w = 17'h1_FFFF;
                3: duty_w = 17'($urandom);
                default: duty_w = 17'($urandom_range(0, 32'h0001_0000));
            endcase
            delay_w = pick_word();
            span = (per_w != '0 && per_w < 31'h0100_0000) ? {per_w[29:0], 2'b00}
                                                           : 32'hFFFF_FFFF;
            case ($urandom_range(0, 4))
                0: step_w = pick_word();
                1: step_w = -$urandom_range(0, span >> 3);
                default: step_w = $urandom_range(0, span >> 3);
            endcase

            cfg_write(REG_HIGH_LEVEL, pick_word());
            cfg_write(REG_LOW_LEVEL, pick_word());
            cfg_write(REG_PERIOD, {1'($urandom), per_w});
            cfg_write(REG_DELAY, delay_w);
            cfg_write(REG_DUTY, {15'($urandom), duty_w});
            cfg_write(REG_MODE, $urandom);
            if ($urandom_range(0, 3) == 0) begin
                cfg_write(REG_START_TIME, pick_word());
            end else begin
                cfg_write(REG_START_TIME, delay_w - (span >> 2) + $urandom_range(0, span >> 1));
            end
            cfg_write(REG_TIME_STEP, step_w);
            cfg_valid <= 1'b0;
            settings_run++;

            count = $urandom_range(30, 100);
            repeat (count) begin
                case ($urandom_range(0, 5))
                    0: tin = $urandom;
                    1: tin = pick_word();
                    2: begin
                        knee = 32'((longint'(per_w) * duty_w) >> FRAC_W);
                        tin  = delay_w + per_w * $urandom_range(0, 3) + knee
                               + $urandom_range(0, 1);
                    end
                    default: tin = delay_w - (span >> 2) + $urandom_range(0, span >> 1);
                endcase
                send_word(tin);
            end
        end

        // Let the last results come back and give the block time to misbehave.
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);
        $display("Sent %0d time words under %0d register settings, %0d levels compared.",
                 words_sent, settings_run, checked);
        $display("Covered external and internal time, zero period, duty above one "
                 , "and accumulator saturation.");
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== pulse_generator.f =====
+incdir+rtl
rtl/pg_pkg.sv
rtl/pg_rem.sv
rtl/pulse_generator.sv
tb/pulse_generator_checker.sv
tb/pulse_generator_tb.sv
